FILE: src/brg_pkg.sv
// ----------------------------------------------------------------------------
// brg_pkg: shared types and constants of the bounded random generator
// Holds the generator constants and the controller-to-datapath command and
// status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package brg_pkg;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned VALUE_W = 63;
	localparam int unsigned MUL_W = 32;

	localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MIX1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MIX2 = 64'h94d049bb133111eb;

	// partial-product multiply phases
	localparam logic [1:0] MP_LL = 2'd0;
	localparam logic [1:0] MP_LH = 2'd1;
	localparam logic [1:0] MP_HL = 2'd2;
	localparam logic [1:0] MP_HH = 2'd3;

	// multiply operand select
	localparam logic [1:0] MS_SM1 = 2'd0;
	localparam logic [1:0] MS_SM2 = 2'd1;
	localparam logic [1:0] MS_DRAW = 2'd2;

	typedef struct packed {
		logic       sm_load;   // load splitmix counter from seed data
		logic       sm_inc;    // advance counter, start mixing
		logic       sm_x1;     // z ^= z>>30, prepare mix1
		logic       sm_x2;     // z ^= z>>27, prepare mix2
		logic       sm_store;  // final mix, shift into state
		logic       mul_clr;   // clear product accumulator
		logic       mul_en;    // accumulate one partial product
		logic [1:0] mul_phase;
		logic [1:0] mul_sel;
		logic       draw;      // draw one word, advance state
		logic       bnd_load;  // latch bound
		logic       div_start;
		logic       div_step;
		logic       res_load;  // latch result from product
		logic       res_err;   // latch error result
	} brg_cmd_t;

	typedef struct packed {
		logic bound_bad;
		logic lo_below_bound;
		logic lo_below_thr;
		logic div_done;
	} brg_sts_t;
endpackage
`default_nettype wire

FILE: src/brg_if.sv
// ----------------------------------------------------------------------------
// brg_if: valid/ready channel
// Generic request channel with a payload of parameter width.
// ----------------------------------------------------------------------------
`default_nettype none
interface brg_if #(parameter int unsigned W = 64) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/brg_out_if.sv
// ----------------------------------------------------------------------------
// brg_out_if: result channel
// Carries the bounded value and the invalid-bound flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface brg_out_if ();
	logic        valid;
	logic        ready;
	logic [62:0] value;
	logic        bound_invalid;
	modport source (output valid, output value, output bound_invalid, input ready);
	modport sink (input valid, input value, input bound_invalid, output ready);
endinterface
`default_nettype wire

FILE: src/brg_datapath.sv
// ----------------------------------------------------------------------------
// brg_datapath: generator state, multiplier and remainder unit
// Holds the xoshiro state, a 32x32 multiply-accumulate that builds 64x64
// products from partial products, and a restoring divider for 2^64 mod bound.
// ----------------------------------------------------------------------------
`default_nettype none
module brg_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire brg_pkg::brg_cmd_t      cmd,
	output brg_pkg::brg_sts_t           sts,
	input  wire logic [63:0]            seed_data,
	input  wire logic [63:0]            bound_in,
	output logic [62:0]                 value,
	output logic                        bound_invalid
);
	import brg_pkg::*;

	logic [63:0] s0_q, s1_q, s2_q, s3_q;
	logic [63:0] ctr_q, z_q;
	logic [63:0] bnd_q, word_q;
	logic [127:0] acc_q;
	logic [63:0] rem_q;
	logic [6:0] div_cnt_q;
	logic [63:0] ma, mb;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	logic [63:0] d_res, d_sh;
	logic [63:0] dvd;
	logic [64:0] rem_sh;
	logic [64:0] rem_try;

	always_comb begin
		case (cmd.mul_sel)
			MS_SM1: begin
				ma = z_q;
				mb = SM_MIX1;
			end
			MS_SM2: begin
				ma = z_q;
				mb = SM_MIX2;
			end
			default: begin
				ma = word_q;
				mb = bnd_q;
			end
		endcase
		case (cmd.mul_phase)
			MP_LL: begin
				pa = ma[31:0];
				pb = mb[31:0];
				pp_sh = {64'd0, pp};
			end
			MP_LH: begin
				pa = ma[31:0];
				pb = mb[63:32];
				pp_sh = {32'd0, pp, 32'd0};
			end
			MP_HL: begin
				pa = ma[63:32];
				pb = mb[31:0];
				pp_sh = {32'd0, pp, 32'd0};
			end
			default: begin
				pa = ma[63:32];
				pb = mb[63:32];
				pp_sh = {pp, 64'd0};
			end
		endcase
	end
	assign pp = {32'd0, pa} * {32'd0, pb};

	// xoshiro256** output and next state
	assign d_res = s1_q * 64'd5;
	assign d_sh = s1_q << 17;

	// remainder of (2^64 - b) mod b equals 2^64 mod b
	assign dvd = 64'd0 - bnd_q;
	assign rem_sh = {rem_q, dvd[~div_cnt_q[5:0]]};
	assign rem_try = rem_sh - {1'b0, bnd_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_clr) acc_q <= '0;
		else if (cmd.mul_en) acc_q <= acc_q + pp_sh;
		if (cmd.sm_load) ctr_q <= seed_data;
		if (cmd.sm_inc) begin
			ctr_q <= ctr_q + SM_GOLDEN;
			z_q <= ctr_q + SM_GOLDEN;
		end
		if (cmd.sm_x1) z_q <= z_q ^ (z_q >> 30);
		if (cmd.sm_x2) z_q <= acc_q[63:0] ^ (acc_q[63:0] >> 27);
		if (cmd.bnd_load) bnd_q <= bound_in;
		if (cmd.draw) word_q <= {d_res[56:0], d_res[63:57]} * 64'd9;
		if (cmd.div_start) begin
			rem_q <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			// dividend is 2^64 - bound: shift in its bits msb first
			if (!rem_try[64]) rem_q <= rem_try[63:0];
			else rem_q <= rem_sh[63:0];
			div_cnt_q <= div_cnt_q + 7'd1;
		end
		if (cmd.res_load) begin
			value <= acc_q[126:64];
			bound_invalid <= 1'b0;
		end else if (cmd.res_err) begin
			value <= '0;
			bound_invalid <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= 64'he220a8397b1dcdaf;
			s1_q <= 64'h6e789e6aa1b965f4;
			s2_q <= 64'h06c45d188009454f;
			s3_q <= 64'hf88bb8a8724c81ec;
		end else if (cmd.sm_store) begin
			s0_q <= s1_q;
			s1_q <= s2_q;
			s2_q <= s3_q;
			s3_q <= acc_q[63:0] ^ (acc_q[63:0] >> 31);
		end else if (cmd.draw) begin
			s2_q <= s2_q ^ s0_q ^ d_sh;
			s3_q <= {(s3_q[18:0] ^ s1_q[18:0]), (s3_q[63:19] ^ s1_q[63:19])};
			s1_q <= s1_q ^ s2_q ^ s0_q;
			s0_q <= s0_q ^ s3_q ^ s1_q;
		end
	end

	assign sts.bound_bad = (bound_in == 64'd0) || bound_in[63];
	assign sts.lo_below_bound = acc_q[63:0] < bnd_q;
	assign sts.lo_below_thr = acc_q[63:0] < rem_q;
	assign sts.div_done = div_cnt_q == 7'd64;
endmodule
`default_nettype wire

FILE: src/brg_ctrl.sv
// ----------------------------------------------------------------------------
// brg_ctrl: sequencing state machine
// Runs seed expansion, draws, multiplies and the rejection test.
// ----------------------------------------------------------------------------
`default_nettype none
module brg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output brg_pkg::brg_cmd_t      cmd,
	input  wire brg_pkg::brg_sts_t sts
);
	import brg_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SM_X1 = 4'd1;
	localparam logic [3:0] ST_SM_M1 = 4'd2;
	localparam logic [3:0] ST_SM_M2 = 4'd3;
	localparam logic [3:0] ST_SM_ST = 4'd4;
	localparam logic [3:0] ST_DRAW = 4'd5;
	localparam logic [3:0] ST_MUL = 4'd6;
	localparam logic [3:0] ST_TEST = 4'd7;
	localparam logic [3:0] ST_DIV = 4'd8;
	localparam logic [3:0] ST_RTEST = 4'd9;
	localparam logic [3:0] ST_SM_INC = 4'd10;
	localparam logic [3:0] ST_SM_X2 = 4'd11;
	localparam logic [3:0] ST_ERR = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] ph_q, ph_d;
	logic [1:0] k_q, k_d;
	logic thr_ok_q, thr_ok_d;
	logic ov_q, ov_d;
	logic out_free;

	assign out_valid = ov_q;
	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ph_d = ph_q;
		k_d = k_q;
		thr_ok_d = thr_ok_q;
		ov_d = ov_q && !out_ready;
		cmd.mul_phase = ph_q;
		case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					cmd.sm_load = 1'b1;
					k_d = '0;
					state_d = ST_SM_INC;
				end else if (in_valid) begin
					cmd.bnd_load = 1'b1;
					if (sts.bound_bad) begin
						if (out_free) begin
							cmd.res_err = 1'b1;
							ov_d = 1'b1;
						end else begin
							state_d = ST_ERR;
						end
					end else begin
						thr_ok_d = 1'b0;
						state_d = ST_DRAW;
					end
				end
			end
			ST_ERR: begin
				// hold the error answer until the output register frees
				if (out_free) begin
					cmd.res_err = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SM_INC: begin
				cmd.sm_inc = 1'b1;
				state_d = ST_SM_X1;
			end
			ST_SM_X1: begin
				cmd.sm_x1 = 1'b1;
				cmd.mul_clr = 1'b1;
				ph_d = MP_LL;
				state_d = ST_SM_M1;
			end
			ST_SM_M1, ST_SM_M2: begin
				cmd.mul_sel = (state_q == ST_SM_M1) ? MS_SM1 : MS_SM2;
				cmd.mul_en = 1'b1;
				ph_d = ph_q + 2'd1;
				// low product half needs only three partial products
				if (ph_q == MP_HL) begin
					ph_d = MP_LL;
					state_d = (state_q == ST_SM_M1) ? ST_SM_X2 : ST_SM_ST;
				end
			end
			ST_SM_X2: begin
				cmd.sm_x2 = 1'b1;
				cmd.mul_clr = 1'b1;
				ph_d = MP_LL;
				state_d = ST_SM_M2;
			end
			ST_SM_ST: begin
				cmd.sm_store = 1'b1;
				k_d = k_q + 2'd1;
				state_d = (k_q == 2'd3) ? ST_IDLE : ST_SM_INC;
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				cmd.mul_clr = 1'b1;
				ph_d = MP_LL;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_sel = MS_DRAW;
				cmd.mul_en = 1'b1;
				ph_d = ph_q + 2'd1;
				if (ph_q == MP_HH) state_d = thr_ok_q ? ST_RTEST : ST_TEST;
			end
			ST_TEST: begin
				if (sts.lo_below_bound) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else if (out_free) begin
					cmd.res_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_step = 1'b0;
					thr_ok_d = 1'b1;
					state_d = ST_RTEST;
				end
			end
			ST_RTEST: begin
				if (sts.lo_below_thr) state_d = ST_DRAW;
				else if (out_free) begin
					cmd.res_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= MP_LL;
			k_q <= '0;
			thr_ok_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q <= ph_d;
			k_q <= k_d;
			thr_ok_q <= thr_ok_d;
			ov_q <= ov_d;
		end
	end
endmodule
`default_nettype wire

FILE: src/bounded_random_generator.sv
// ----------------------------------------------------------------------------
// bounded_random_generator: seeded uniform integer source
// xoshiro256** generator with multiply-and-reject reduction to [0, bound).
// ----------------------------------------------------------------------------
// A request with a positive bound is accepted in idle; a word is drawn,
// the 64x64 product is built from four partial products on the shared
// 32x32 multiplier and tested, and the result is loaded once the output
// register is free; the next request can be taken on the following cycle.
// When the low product half falls below the bound, a restoring divider forms
// 2^64 mod bound (64 steps, then a done check), the product is tested against
// it, and each redraw repeats draw, product and threshold test. A bound of
// zero or less gets the error answer once the output register frees. A
// request is taken while an earlier result still waits; a finished result
// holds until the output register frees. A seed write runs four splitmix64 steps.
`default_nettype none
module bounded_random_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	brg_if.sink       cfg,
	brg_if.sink       req,
	brg_out_if.source rsp
);
	import brg_pkg::*;

	brg_cmd_t cmd;
	brg_sts_t sts;

	brg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	brg_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seed_data     (cfg.data),
		.bound_in      (req.data),
		.value         (rsp.value),
		.bound_invalid (rsp.bound_invalid)
	);
endmodule
`default_nettype wire
